FILE: rtl/sha256_byte_stream_hasher_assert.svh
// assertion macros for the sha-256 byte stream hasher
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// property that must hold on every rising clock edge outside reset
`define SHA_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication with the consequent checked in the next cycle
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sha_pkg.sv
// shared types, constants and round functions for the sha-256 hasher
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       message_end;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    // transaction from the queue to the core
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       message_end;
    } sha_cmd_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    typedef logic [31:0] word_t;

    localparam word_t INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;

    function automatic word_t ror(input word_t v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic word_t sig0(input word_t x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t sig1(input word_t x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t big_sig0(input word_t x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic word_t big_sig1(input word_t x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

endpackage

FILE: rtl/sha_queue.sv
// short fifo between the front end and the hashing core
module sha_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sha_pkg::sha_cmd_t in_cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output sha_pkg::sha_cmd_t out_cmd
);
    import sha_pkg::*;

    sha_cmd_t            mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                push;
    logic                pop;

    assign in_ready  = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: rtl/sha_core.sv
// block buffer, padding sequencer, 64-round compression and digest output
module sha_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  sha_pkg::sha_cmd_t  cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output sha_pkg::sha_out_t  out_item
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_ADD,
        S_EMIT
    } state_t;

    state_t      state_reg;
    word_t       h_reg [8];
    word_t       v_reg [8];
    word_t       w_reg [16];
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [5:0]  round_reg;
    logic        final_reg;
    logic        len_done_reg;
    logic [2:0]  emit_idx_reg;
    logic        pad_flag_reg;

    word_t t1;
    word_t t2;
    word_t w_new;
    word_t w_cur;
    logic  byte_in;
    logic  end_in;
    logic [5:0] fill_after;

    assign cmd_ready  = (state_reg == S_IDLE);
    assign byte_in    = cmd_valid && cmd.byte_present;
    assign end_in     = cmd_valid && cmd.message_end;
    assign fill_after = fill_reg + {5'd0, byte_in};

    // message schedule word for this round sits at w_reg[0]
    assign w_cur = w_reg[0];
    assign w_new = sig1(w_reg[14]) + w_reg[9] + sig0(w_reg[1]) + w_reg[0];
    assign t1 = v_reg[7] + big_sig1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + ROUND_K[round_reg] + w_cur;
    assign t2 = big_sig0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    assign out_valid            = (state_reg == S_EMIT);
    assign out_item.digest_word = h_reg[emit_idx_reg];
    assign out_item.word_index  = emit_idx_reg;
    assign out_item.last_word   = (emit_idx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            bits_reg     <= '0;
            round_reg    <= '0;
            final_reg    <= 1'b0;
            len_done_reg <= 1'b0;
            emit_idx_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= INIT_H[i];
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        if (byte_in)
                        begin
                            bits_reg <= bits_reg + 64'd8;
                            fill_reg <= fill_reg + 6'd1;
                        end
                        if (byte_in && fill_reg == 6'd63)
                        begin
                            final_reg <= end_in;
                            len_done_reg <= 1'b0;
                            round_reg <= '0;
                            state_reg <= S_ROUND;
                        end
                        else if (end_in)
                        begin
                            final_reg <= 1'b1;
                            // length fits when the pad byte leaves eight bytes free
                            len_done_reg <= (fill_after < LEN_POS);
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    fill_reg <= fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                    begin
                        round_reg <= '0;
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63)
                    begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    fill_reg <= '0;
                    if (!final_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (len_done_reg)
                    begin
                        emit_idx_reg <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        // extra block always carries the length
                        len_done_reg <= 1'b1;
                        state_reg <= S_PAD;
                    end
                end
                S_EMIT:
                begin
                    if (out_ready)
                    begin
                        emit_idx_reg <= emit_idx_reg + 3'd1;
                        if (emit_idx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= INIT_H[i];
                            end
                            bits_reg <= '0;
                            fill_reg <= '0;
                            final_reg <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload path: buffer words, schedule window and working variables
    logic [7:0] pad_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_flag_reg <= 1'b0;
        end
        else if (state_reg == S_IDLE && end_in)
        begin
            pad_flag_reg <= 1'b0;
        end
        else if (state_reg == S_PAD)
        begin
            pad_flag_reg <= 1'b1;
        end
    end

    // byte for the current padding position
    always_comb
    begin
        if (!pad_flag_reg)
        begin
            pad_byte = PAD_BYTE;
        end
        else if (len_done_reg && fill_reg >= LEN_POS)
        begin
            pad_byte = bits_reg[{~fill_reg[2:0], 3'b000} +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    logic [7:0] put_byte;
    logic       put_en;

    assign put_en   = (state_reg == S_IDLE && byte_in) || (state_reg == S_PAD);
    assign put_byte = (state_reg == S_PAD) ? pad_byte : cmd.data_byte;

    // shift one byte into the buffer; the buffer is the schedule window
    always_ff @(posedge clk)
    begin
        if (put_en)
        begin
            w_reg[fill_reg[5:2]] <= {w_reg[fill_reg[5:2]][23:0], put_byte};
        end
        else if (state_reg == S_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
        end
        if ((state_reg == S_IDLE && byte_in && fill_reg == 6'd63)
            || (state_reg == S_PAD && fill_reg == 6'd63))
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (state_reg == S_ROUND)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule

FILE: rtl/sha256_byte_stream_hasher.sv
// sha-256 byte stream hasher top level
// Bytes arrive one per transaction and are queued in a four-entry fifo ahead of
// the hashing core; the core absorbs each byte while idle, and the 64th byte of a
// block starts the 64-round compression, one round per cycle, followed by an add
// into the running hash; the core takes no transactions meanwhile. An end
// transaction pads in place (byte by byte, with a second block when fewer than
// nine bytes of room remain) and then hands out the digest as eight 32-bit
// transactions, most significant word first, before the next message starts.
module sha256_byte_stream_hasher (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sha_pkg::sha_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output sha_pkg::sha_out_t out_data
);
    import sha_pkg::*;
    `include "sha256_byte_stream_hasher_assert.svh"

    sha_cmd_t q_in;
    sha_cmd_t q_out;
    logic     q_valid;
    logic     q_ready;

    assign q_in.data_byte    = in_data.data_byte;
    assign q_in.byte_present = in_data.byte_present;
    assign q_in.message_end  = in_data.message_end;

    sha_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_cmd    (q_in),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_out)
    );

    sha_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_out),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_data)
    );

    `SHA_ASSERT_ALWAYS(a_last_index, !out_valid || (out_data.last_word == (out_data.word_index == 3'd7)), "last_word out of step with word_index")
    `SHA_ASSERT_NEXT(a_core_busy, out_valid && q_ready, 1'b0, "core takes a transaction while emitting")
    `SHA_ASSERT_NEXT(a_word_advance, out_valid && out_ready && out_data.word_index != 3'd7, out_valid, "digest stream broken")

endmodule

FILE: test/tb_top.sv
// testbench for the sha-256 byte stream hasher: queued directed and random messages, digest checking
module tb_top;
    import sha_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    sha_in_t in_data;
    logic out_valid;
    logic out_ready;
    sha_out_t out_data;

    sha256_byte_stream_hasher i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    typedef logic [31:0] u32_t;

    localparam u32_t K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam u32_t H_START [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    u32_t run_hash [8];
    logic [7:0] blk_bytes [64];
    int fill_cnt;
    logic [63:0] bit_len;

    sha_in_t pending_items [$];
    sha_out_t digest_words [$];
    int errors;
    int idle_cycles;
    int send_gap;
    int recv_gap;
    bit long_hold_done;
    int accepted_in;
    logic in_ready_seen;
    logic out_fire_seen;

    function automatic u32_t rotr(u32_t v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic compress_blk();
        u32_t w [64];
        u32_t v [8];
        u32_t t1;
        u32_t t2;
        for (int r = 0; r < 16; r++)
            w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
        for (int r = 16; r < 64; r++)
            w[r] = (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
                + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
        v = run_hash;
        for (int r = 0; r < 64; r++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + w[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int r = 0; r < 8; r++)
            run_hash[r] += v[r];
    endtask

    task automatic predict_digest(sha_in_t it);
        int pos;
        sha_out_t o;
        if (it.byte_present)
        begin
            blk_bytes[fill_cnt] = it.data_byte;
            bit_len += 64'd8;
            fill_cnt++;
            if (fill_cnt == 64)
            begin
                compress_blk();
                fill_cnt = 0;
            end
        end
        if (it.message_end)
        begin
            pos = fill_cnt;
            blk_bytes[pos] = PAD_BYTE;
            pos++;
            if (pos > 56)
            begin
                for (int k = pos; k < 64; k++)
                    blk_bytes[k] = 8'h00;
                compress_blk();
                pos = 0;
            end
            for (int k = pos; k < 56; k++)
                blk_bytes[k] = 8'h00;
            for (int j = 0; j < 8; j++)
                blk_bytes[56+j] = bit_len[8*(7-j) +: 8];
            compress_blk();
            for (int j = 0; j < 8; j++)
            begin
                o.digest_word = run_hash[j];
                o.word_index = 3'(j);
                o.last_word = (j == 7);
                digest_words.push_back(o);
            end
            run_hash = H_START;
            fill_cnt = 0;
            bit_len = '0;
        end
    endtask

    function automatic int rand_gap();
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 120);
        return $urandom_range(1, 3);
    endfunction

    function automatic sha_in_t mk_item(logic [7:0] b, logic p, logic e);
        sha_in_t it;
        it.data_byte = b;
        it.byte_present = p;
        it.message_end = e;
        return it;
    endfunction

    task automatic add_message(int len, bit end_with_byte);
        for (int i = 0; i < len; i++)
            pending_items.push_back(mk_item(8'($urandom), 1'b1,
                end_with_byte && i == len - 1));
        if (!end_with_byte || len == 0)
            pending_items.push_back(mk_item(8'($urandom), 1'b0, 1'b1));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        int n;
        run_hash = H_START;
        fill_cnt = 0;
        bit_len = '0;
        // directed: empty, byte extremes, padding boundaries
        add_message(0, 0);
        pending_items.push_back(mk_item(8'h00, 1'b1, 1'b1));
        pending_items.push_back(mk_item(8'hff, 1'b1, 1'b1));
        pending_items.push_back(mk_item(8'hff, 1'b0, 1'b0));
        pending_items.push_back(mk_item(8'h5a, 1'b1, 1'b0));
        pending_items.push_back(mk_item(8'ha5, 1'b0, 1'b1));
        add_message(3, 1);
        add_message(55, 0);
        add_message(56, 1);
        add_message(63, 0);
        add_message(64, 1);
        n = 0;
        while (n < 50)
        begin
            int len;
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 12);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    pending_items.push_back(mk_item(8'($urandom), 1'b0, 1'b0));
                pending_items.push_back(mk_item(8'($urandom), 1'b1, 1'b0));
            end
            if ($urandom_range(0, 1) == 0)
                pending_items.push_back(mk_item(8'($urandom), 1'b1, 1'b1));
            else
                pending_items.push_back(mk_item(8'($urandom), 1'b0, 1'b1));
            n += len + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_gap <= 0;
        end
        else if (!in_valid || in_ready_seen)
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_items.size() > 0)
            begin
                in_valid <= 1'b1;
                in_data <= pending_items.pop_front();
                send_gap <= rand_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ready_seen <= 1'b0;
            out_fire_seen <= 1'b0;
            errors = 0;
            idle_cycles <= 0;
            accepted_in <= 0;
        end
        else
        begin
            in_ready_seen <= in_valid && in_ready;
            out_fire_seen <= out_valid && out_ready;
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && in_ready)
            begin
                predict_digest(in_data);
                accepted_in <= accepted_in + 1;
            end
            if (out_valid && out_ready)
            begin
                if (digest_words.size() == 0)
                begin
                    $error("digest word with none expected: %h", out_data.digest_word);
                    errors++;
                end
                else
                begin
                    sha_out_t exp_o;
                    exp_o = digest_words.pop_front();
                    if (out_data.digest_word !== exp_o.digest_word)
                    begin
                        $error("digest_word expected %h actual %h",
                            exp_o.digest_word, out_data.digest_word);
                        errors++;
                    end
                    if (out_data.word_index !== exp_o.word_index)
                    begin
                        $error("word_index expected %0d actual %0d",
                            exp_o.word_index, out_data.word_index);
                        errors++;
                    end
                    if (out_data.last_word !== exp_o.last_word)
                    begin
                        $error("last_word expected %0d actual %0d",
                            exp_o.last_word, out_data.last_word);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver with one long hold-off while input keeps coming
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap <= 0;
            long_hold_done <= 1'b0;
        end
        else if (!long_hold_done && accepted_in > 130)
        begin
            out_ready <= 1'b0;
            recv_gap <= 400;
            long_hold_done <= 1'b1;
        end
        else if (recv_gap > 0)
        begin
            out_ready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (out_fire_seen)
                recv_gap <= rand_gap();
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (!(pending_items.size() == 0 && !in_valid && digest_words.size() == 0)
            && idle_cycles < STALL_LIMIT)
            @(posedge clk);
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL sha256_byte_stream_hasher");
            $finish;
        end
        else
        begin
            repeat (300) @(posedge clk);
            if (errors == 0 && digest_words.size() == 0)
                $display("PASS sha256_byte_stream_hasher");
            else
                $display("FAIL sha256_byte_stream_hasher");
            $finish;
        end
    end

endmodule
